[hdl/kvt_pkg.sv]
package kvt_pkg;

  // Table geometry.
  localparam int MAX_ENTRIES = 256;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = ADDR_W + 1;

  // Field widths.
  localparam int OP_W    = 3;
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 64;
  localparam int SLOT_W  = 8;
  localparam int CAP_W   = 9;

  // Configuration port.
  localparam int        PADDR_W       = 3;
  localparam int        PDATA_W       = 32;
  localparam logic      REG_CAPACITY  = 1'b0;
  localparam logic [CAP_W-1:0] CAPACITY_RESET = 9'd256;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
  localparam logic [OP_W-1:0] OP_UPDATE    = 3'd1;
  localparam logic [OP_W-1:0] OP_UPSERT    = 3'd2;
  localparam logic [OP_W-1:0] OP_ERASE     = 3'd3;
  localparam logic [OP_W-1:0] OP_LOOKUP    = 3'd4;
  localparam logic [OP_W-1:0] OP_READ_SLOT = 3'd5;

  // How the back end handles an item.
  typedef enum logic [1:0] {
    KIND_SEARCH,
    KIND_SLOT,
    KIND_NONE
  } kind_t;

  // A classified item waiting for the back end.
  typedef struct packed {
    logic [OP_W-1:0]    op;
    kind_t              kind;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic [SLOT_W-1:0]  slot;
  } req_t;

  // One finished result.
  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] value_out;
    logic [KEY_W-1:0]   key_out;
    logic [CAP_W-1:0]   entry_count;
    logic               is_empty;
  } res_t;

endpackage

[hdl/kvt_front.sv]
module kvt_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [kvt_pkg::OP_W-1:0]      op,
  input  logic [kvt_pkg::KEY_W-1:0]     key,
  input  logic [kvt_pkg::VALUE_W-1:0]   value,
  input  logic [kvt_pkg::SLOT_W-1:0]    slot,
  output logic                          req_valid,
  output kvt_pkg::req_t                 req,
  input  logic                          req_pop
);

  kvt_pkg::req_t   fifo [2];
  kvt_pkg::req_t   incoming;
  kvt_pkg::kind_t  kind;
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      cnt;
  logic            push_ok;
  logic            pop_ok;

  // Classify the operation so the back end knows whether to search.
  always_comb begin
    if (op inside {kvt_pkg::OP_INSERT, kvt_pkg::OP_UPDATE, kvt_pkg::OP_UPSERT,
                   kvt_pkg::OP_ERASE, kvt_pkg::OP_LOOKUP}) begin
      kind = kvt_pkg::KIND_SEARCH;
    end else if (op == kvt_pkg::OP_READ_SLOT) begin
      kind = kvt_pkg::KIND_SLOT;
    end else begin
      kind = kvt_pkg::KIND_NONE;
    end
  end

  assign incoming = '{op: op, kind: kind, key: key, value: value, slot: slot};

  // Two-entry queue between the front and the back end.
  assign full      = (cnt == 2'd2);
  assign req_valid = (cnt != 2'd0);
  assign req       = fifo[rd_ptr];
  assign push_ok   = push && !full;
  assign pop_ok    = req_pop && req_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push_ok) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push_ok && !pop_ok) begin
        cnt <= cnt + 2'd1;
      end else if (!push_ok && pop_ok) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

  // Queue payload needs no reset.
  always_ff @(posedge clk) begin
    if (push_ok) begin
      fifo[wr_ptr] <= incoming;
    end
  end

endmodule

[hdl/kvt_back.sv]
module kvt_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [kvt_pkg::CAP_W-1:0]     capacity,
  input  logic                          req_valid,
  input  kvt_pkg::req_t                 req,
  output logic                          req_pop,
  output logic                          res_valid,
  output kvt_pkg::res_t                 res,
  input  logic                          res_pop
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_ISSUE  = 4'b0100,
    S_DATA   = 4'b1000
  } state_t;

  state_t                           state, state_next;
  kvt_pkg::req_t                    r, r_next;
  logic [kvt_pkg::CNT_W-1:0]        scan, scan_next;
  logic                             pend, pend_next;
  logic [kvt_pkg::ADDR_W-1:0]       pend_pos, pend_pos_next;
  logic [kvt_pkg::ADDR_W-1:0]       pos, pos_next;
  logic [kvt_pkg::ADDR_W-1:0]       rd_ptr, rd_ptr_next;
  logic [kvt_pkg::CNT_W-1:0]        fill, fill_next;
  kvt_pkg::res_t                    res_next;
  logic                             res_valid_next;

  // Entry storage.
  logic [kvt_pkg::KEY_W-1:0]        key_mem [kvt_pkg::MAX_ENTRIES];
  logic [kvt_pkg::VALUE_W-1:0]      val_mem [kvt_pkg::MAX_ENTRIES];
  logic [kvt_pkg::KEY_W-1:0]        key_q;
  logic [kvt_pkg::VALUE_W-1:0]      val_q;
  logic [kvt_pkg::ADDR_W-1:0]       rd_addr;
  logic [kvt_pkg::ADDR_W-1:0]       waddr;
  logic                             kwe, vwe;
  logic [kvt_pkg::KEY_W-1:0]        kwdata;
  logic [kvt_pkg::VALUE_W-1:0]      vwdata;

  logic [kvt_pkg::CNT_W-1:0]        limit;
  logic [kvt_pkg::CNT_W-1:0]        last;
  logic                             hit, miss, can_append;
  logic                             fin, fin_ok;
  logic [kvt_pkg::VALUE_W-1:0]      fin_vout;
  logic [kvt_pkg::KEY_W-1:0]        fin_kout;

  // Effective capacity and search status.
  assign limit      = (capacity > kvt_pkg::CNT_W'(kvt_pkg::MAX_ENTRIES)) ?
                      kvt_pkg::CNT_W'(kvt_pkg::MAX_ENTRIES) : capacity;
  assign last       = fill - kvt_pkg::CNT_W'(1);
  assign hit        = pend && (key_q == r.key);
  assign miss       = !pend && (scan >= fill);
  assign can_append = (fill < limit);

  // Sequencer: search one slot per cycle for keyed operations, then modify or read; a slot read skips the search.
  always_comb begin
    state_next     = state;
    r_next         = r;
    scan_next      = scan;
    pend_next      = pend;
    pend_pos_next  = pend_pos;
    pos_next       = pos;
    rd_ptr_next    = rd_ptr;
    fill_next      = fill;
    res_next       = res;
    res_valid_next = res_valid && !res_pop;
    req_pop        = 1'b0;
    rd_addr        = rd_ptr;
    kwe            = 1'b0;
    vwe            = 1'b0;
    waddr          = pos;
    kwdata         = r.key;
    vwdata         = r.value;
    fin            = 1'b0;
    fin_ok         = 1'b0;
    fin_vout       = '0;
    fin_kout       = '0;

    case (state)
      S_IDLE: begin
        if (req_valid && !res_valid) begin
          req_pop   = 1'b1;
          r_next    = req;
          scan_next = '0;
          pend_next = 1'b0;
          case (req.kind)
            kvt_pkg::KIND_SEARCH: begin
              state_next = S_SEARCH;
            end
            kvt_pkg::KIND_SLOT: begin
              if ({1'b0, req.slot} < fill) begin
                rd_ptr_next = req.slot;
                state_next  = S_ISSUE;
              end else begin
                fin = 1'b1;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      S_SEARCH: begin
        rd_addr = scan[kvt_pkg::ADDR_W-1:0];
        if (hit) begin
          case (r.op)
            kvt_pkg::OP_UPDATE, kvt_pkg::OP_UPSERT: begin
              vwe    = 1'b1;
              waddr  = pend_pos;
              fin    = 1'b1;
              fin_ok = 1'b1;
            end
            kvt_pkg::OP_ERASE: begin
              pos_next    = pend_pos;
              rd_ptr_next = last[kvt_pkg::ADDR_W-1:0];
              state_next  = S_ISSUE;
            end
            kvt_pkg::OP_LOOKUP: begin
              rd_ptr_next = pend_pos;
              state_next  = S_ISSUE;
            end
            default: begin
              // Insert of a key already present fails.
              fin = 1'b1;
            end
          endcase
        end else if (miss) begin
          if ((r.op == kvt_pkg::OP_INSERT || r.op == kvt_pkg::OP_UPSERT) && can_append) begin
            kwe       = 1'b1;
            vwe       = 1'b1;
            waddr     = fill[kvt_pkg::ADDR_W-1:0];
            fill_next = fill + kvt_pkg::CNT_W'(1);
            fin_ok    = 1'b1;
          end
          fin = 1'b1;
        end else if (scan < fill) begin
          pend_next     = 1'b1;
          pend_pos_next = scan[kvt_pkg::ADDR_W-1:0];
          scan_next     = scan + kvt_pkg::CNT_W'(1);
        end else begin
          pend_next = 1'b0;
        end
      end

      S_ISSUE: begin
        state_next = S_DATA;
      end

      S_DATA: begin
        fin    = 1'b1;
        fin_ok = 1'b1;
        case (r.op)
          kvt_pkg::OP_ERASE: begin
            // Move the last entry into the freed slot.
            kwe       = 1'b1;
            vwe       = 1'b1;
            waddr     = pos;
            kwdata    = key_q;
            vwdata    = val_q;
            fill_next = fill - kvt_pkg::CNT_W'(1);
          end
          kvt_pkg::OP_LOOKUP: begin
            fin_vout = val_q;
          end
          default: begin
            fin_vout = val_q;
            fin_kout = key_q;
          end
        endcase
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Every item ends with one result in the output register.
    if (fin) begin
      state_next     = S_IDLE;
      res_valid_next = 1'b1;
      res_next       = '{ok: fin_ok, value_out: fin_vout, key_out: fin_kout,
                         entry_count: fill_next, is_empty: (fill_next == '0)};
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      res_valid <= res_valid_next;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    r        <= r_next;
    scan     <= scan_next;
    pend     <= pend_next;
    pend_pos <= pend_pos_next;
    pos      <= pos_next;
    rd_ptr   <= rd_ptr_next;
    res      <= res_next;
  end

  // Key and value memories: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (kwe) begin
      key_mem[waddr] <= kwdata;
    end
    key_q <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (vwe) begin
      val_mem[waddr] <= vwdata;
    end
    val_q <= val_mem[rd_addr];
  end

endmodule

[hdl/key_value_table.sv]
// Items enter a two-entry input queue. The back end takes one when idle with its result register
// free, scans the key memory one slot a cycle for keyed operations, then modifies or reads;
// a slot read skips the search, and an unused op or a slot past the fill fails without access.
// A new item is started only after the last result is popped; until then up to two items wait
// in the input queue.
// Reset (synchronous, active high) empties the table and queues and sets capacity to 256.
module key_value_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kvt_pkg::PADDR_W-1:0]   paddr,
  input  logic [kvt_pkg::PDATA_W-1:0]   pwdata,
  output logic [kvt_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          push,
  output logic                          full,
  input  logic [kvt_pkg::OP_W-1:0]      op,
  input  logic [kvt_pkg::KEY_W-1:0]     key,
  input  logic [kvt_pkg::VALUE_W-1:0]   value,
  input  logic [kvt_pkg::SLOT_W-1:0]    slot,
  output logic                          empty,
  input  logic                          pop,
  output logic                          ok,
  output logic [kvt_pkg::VALUE_W-1:0]   value_out,
  output logic [kvt_pkg::KEY_W-1:0]     key_out,
  output logic [kvt_pkg::CAP_W-1:0]     entry_count,
  output logic                          is_empty
);

  logic [kvt_pkg::CAP_W-1:0] capacity;
  logic                      cap_sel;
  logic                      req_valid;
  logic                      req_pop;
  kvt_pkg::req_t             req;
  logic                      res_valid;
  kvt_pkg::res_t             res;

  // Configuration register.
  assign pready  = 1'b1;
  assign cap_sel = (paddr[kvt_pkg::PADDR_W-1] == kvt_pkg::REG_CAPACITY);
  assign prdata  = cap_sel ? kvt_pkg::PDATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= kvt_pkg::CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready && cap_sel) begin
      capacity <= pwdata[kvt_pkg::CAP_W-1:0];
    end
  end

  // Front end: classify and queue incoming items.
  kvt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .op        (op),
    .key       (key),
    .value     (value),
    .slot      (slot),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop)
  );

  // Back end: search, modify and hold the result.
  kvt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .capacity  (capacity),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (pop && res_valid)
  );

  // Result side.
  assign empty       = !res_valid;
  assign ok          = res.ok;
  assign value_out   = res.value_out;
  assign key_out     = res.key_out;
  assign entry_count = res.entry_count;
  assign is_empty    = res.is_empty;

endmodule

[hdl/kvt_checker.sv]
module kvt_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          push,
  input logic                          full,
  input logic                          pop,
  input logic                          empty,
  input logic                          ok,
  input logic [kvt_pkg::VALUE_W-1:0]   value_out,
  input logic [kvt_pkg::KEY_W-1:0]     key_out,
  input logic [kvt_pkg::CAP_W-1:0]     entry_count,
  input logic                          is_empty
);

  // Reset leaves the result side empty and the input queue not full.
  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not empty after reset");

  // The empty flag agrees with the entry count.
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    (!empty && !push) |-> (is_empty == (entry_count == 9'd0)))
    else $error("is_empty does not match entry_count");

  // The table never reports more entries than it can hold.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (entry_count <= 9'(kvt_pkg::MAX_ENTRIES)))
    else $error("entry_count above table size");

  // A failed item returns no key and no value.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && !ok) |-> (value_out == 64'd0 && key_out == 32'd0))
    else $error("failed item returns data");

  // A waiting result holds until it is taken.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(entry_count) && $stable(ok)))
    else $error("waiting result changed");

endmodule

bind key_value_table kvt_checker u_kvt_checker (.*);
